### design/dps_pkg.sv
// Shared types and constants for the descending pair sorter.
package dps_pkg;

    localparam int POS_W   = 8;
    localparam int SCORE_W = 32;
    localparam int POT_W   = 4;
    localparam int RANK_W  = 6;
    localparam int TOP_W   = 7;
    localparam int MAX_OUT = 64;

    typedef struct packed {
        logic [POS_W-1:0]          position;
        logic signed [SCORE_W-1:0] score;
        logic                      final_item;
    } in_req_t;

    typedef struct packed {
        logic [POS_W-1:0]          out_position;
        logic signed [SCORE_W-1:0] out_score;
        logic [RANK_W-1:0]         rank_index;
        logic                      end_of_list;
        logic                      overflowed;
    } result_t;

    // One stored pair plus its cached cell potential
    typedef struct packed {
        logic [POS_W-1:0]          position;
        logic signed [SCORE_W-1:0] score;
        logic [POT_W-1:0]          potential;
    } slot_t;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

endpackage

### design/dps_cell.sv
// One cell of the insertion chain: holds a pair, compares and hands data on.
module dps_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 9
) (
    input  logic               clk,
    input  dps_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]   count,
    input  dps_pkg::slot_t     in_slot,
    input  dps_pkg::slot_t     prev_slot,
    input  logic               prev_below,
    input  dps_pkg::slot_t     next_slot,
    output dps_pkg::slot_t     slot,
    output logic               below
);
    import dps_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;
    logic  occupied;
    logic  outranked;

    assign occupied  = count > CNT_W'(IDX);
    // stored pair ranks strictly below the incoming one
    assign outranked = (slot_reg.score < in_slot.score) ||
                       ((slot_reg.score == in_slot.score) &&
                        (slot_reg.potential < in_slot.potential));
    assign below     = !occupied || outranked;
    assign slot      = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.insert)
        begin
            if (prev_below)
            begin
                slot_next = prev_slot;
            end
            else if (below)
            begin
                slot_next = in_slot;
            end
        end
        else if (ctrl.shift_out)
        begin
            slot_next = next_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

### design/descending_pair_sorter.sv
// Top level of the descending pair sorter: insertion chain and run control.
//
// Usage:
//  - Request channel: raise start with req (position, score, final_item).
//    A request is taken on a rising edge with start high and busy low.
//  - Each request is inserted into a row of CAPACITY cells; the
//    chain stays sorted by score, ties by cell potential (distance from the
//    board edge), fully equal pairs in arrival order.
//  - A request with final_item set is inserted, then busy rises and the best
//    min(count, top_count) pairs are shifted out of the head cell, one per
//    cycle. The first result passes through the state register and then the
//    result register after the final request is taken; busy falls as the last one appears.
//  - Non-final requests: one per cycle while busy is low, no result.
//  - Results appear on result for exactly one cycle with result_valid high;
//    the receiver cannot stall them. The last carries end_of_list, and
//    overflowed if requests were dropped because the chain was full.
//  - cfg_we/cfg_data write top_count (0 acts as 1, above 64 as 64).
//  - Reset clears the pair count, the overflow flag and the state, and sets
//    top_count to 64. No clearing pass: cell contents are qualified by count.
module descending_pair_sorter #(
    parameter int CAPACITY   = 256,
    parameter int BOARD_SIDE = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  dps_pkg::in_req_t              req,
    input  logic                          cfg_we,
    input  logic [dps_pkg::TOP_W-1:0]     cfg_data,
    output logic                          result_valid,
    output dps_pkg::result_t              result
);
    import dps_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > TOP_W) ? CNT_W : TOP_W;

    // potential of every encodable position, built at elaboration
    logic [POT_W-1:0] pot_tab [256];

    for (genvar p = 0; p < 256; p++)
    begin : g_pot
        localparam int R  = p / BOARD_SIDE;
        localparam int C  = p % BOARD_SIDE;
        localparam int FR = BOARD_SIDE - 1 - R;
        localparam int FC = BOARD_SIDE - 1 - C;
        localparam int M1 = (R < C) ? R : C;
        localparam int M2 = (FR < FC) ? FR : FC;
        localparam int M  = (M1 < M2) ? M1 : M2;
        assign pot_tab[p] = (p < BOARD_SIDE * BOARD_SIDE) ? POT_W'(M) : '0;
    end

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [TOP_W-1:0]   top_reg, top_next;
    logic [RANK_W-1:0]  rank_reg, rank_next;
    logic [RANK_W-1:0]  last_rank_reg, last_rank_next;
    logic               result_valid_reg, result_valid_next;
    result_t            result_reg, result_next;

    logic               accept;
    logic               full;
    cell_ctrl_t         ctrl;
    slot_t              in_slot;
    logic [CW-1:0]      cnt_after;
    logic [CW-1:0]      limit;
    logic [CW-1:0]      total;

    slot_t              slots [CAPACITY];
    logic               belows [CAPACITY];

    assign busy   = (state_reg == ST_EMIT);
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(CAPACITY));

    assign in_slot.position  = req.position;
    assign in_slot.score     = req.score;
    assign in_slot.potential = pot_tab[req.position];

    // the chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        slot_t prev_s;
        slot_t next_s;
        logic  prev_b;

        if (i == 0)
        begin : g_head
            assign prev_s = in_slot;
            assign prev_b = 1'b0;
        end
        else
        begin : g_body
            assign prev_s = slots[i-1];
            assign prev_b = belows[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_s = slots[i];
        end
        else
        begin : g_mid
            assign next_s = slots[i+1];
        end

        dps_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .in_slot    (in_slot),
            .prev_slot  (prev_s),
            .prev_below (prev_b),
            .next_slot  (next_s),
            .slot       (slots[i]),
            .below      (belows[i])
        );
    end

    // run length: min(pairs held after this insert, clamped top_count)
    always_comb
    begin
        cnt_after = full ? CW'(count_reg) : CW'(count_reg) + CW'(1);
        priority if (top_reg == '0)
        begin
            limit = CW'(1);
        end
        else if (top_reg > TOP_W'(MAX_OUT))
        begin
            limit = CW'(MAX_OUT);
        end
        else
        begin
            limit = CW'(top_reg);
        end
        total = (cnt_after < limit) ? cnt_after : limit;
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        ovf_next          = ovf_reg;
        top_next          = cfg_we ? cfg_data : top_reg;
        rank_next         = rank_reg;
        last_rank_next    = last_rank_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        ctrl.insert       = 1'b0;
        ctrl.shift_out    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                    if (req.final_item)
                    begin
                        state_next     = ST_EMIT;
                        rank_next      = '0;
                        last_rank_next = RANK_W'(total - CW'(1));
                    end
                end
            end
            ST_EMIT:
            begin
                ctrl.shift_out           = 1'b1;
                result_valid_next        = 1'b1;
                result_next.out_position = slots[0].position;
                result_next.out_score    = slots[0].score;
                result_next.rank_index   = rank_reg;
                result_next.end_of_list  = (rank_reg == last_rank_reg);
                result_next.overflowed   = (rank_reg == last_rank_reg) && ovf_reg;
                rank_next                = rank_reg + RANK_W'(1);
                if (rank_reg == last_rank_reg)
                begin
                    state_next = ST_IDLE;
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            top_reg          <= TOP_W'(MAX_OUT);
            rank_reg         <= '0;
            last_rank_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            ovf_reg          <= ovf_next;
            top_reg          <= top_next;
            rank_reg         <= rank_next;
            last_rank_reg    <= last_rank_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### design/dps_checker.sv
// Port-level checker for the descending pair sorter, bound to the top level.
module dps_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input dps_pkg::in_req_t          req,
    input logic                      result_valid,
    input dps_pkg::result_t          result
);
    import dps_pkg::*;

    // a run's results come back to back with rising rank
    a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.end_of_list |=>
            result_valid && (result.rank_index == $past(result.rank_index) + RANK_W'(1)))
        else $error("rank sequence broken");

    a_first_rank: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> (result.rank_index == '0))
        else $error("run does not start at rank zero");

    a_ovf_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.overflowed |-> result.end_of_list)
        else $error("overflow flag off the last result");

    a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.final_item |=> busy)
        else $error("final request did not start a run");

    a_idle_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.end_of_list |-> !busy)
        else $error("still busy on last result");

endmodule

bind descending_pair_sorter dps_checker u_dps_checker (.*);

### tb/tb_descending_pair_sorter.sv
// Self-checking testbench for the descending pair sorter: directed and random request sets.
`timescale 1ns / 100ps

module tb_descending_pair_sorter;
    import dps_pkg::*;

    // Block geometry, matching the instance below
    localparam int CAPACITY    = 256;
    localparam int BOARD_SIDE  = 15;
    localparam int BOARD_CELLS = BOARD_SIDE * BOARD_SIDE;

    // Generous ceiling on run length; a correct run needs well under a tenth of it
    localparam int CYCLE_LIMIT = 400000;

    // Cycles to let pass after the last expected result before touching top_count
    localparam int SETTLE_CYCLES = 4;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            start;
    logic            busy;
    in_req_t         req;
    logic            cfg_we;
    logic [TOP_W-1:0] cfg_data;
    logic            result_valid;
    result_t         result;

    descending_pair_sorter #(
        .CAPACITY   (CAPACITY),
        .BOARD_SIDE (BOARD_SIDE)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Ranking predictor state: its own copy of the sorted store, the pair
    // count, the overflow flag and the top_count register.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]          held_pos   [CAPACITY];
    logic signed [SCORE_W-1:0] held_score [CAPACITY];
    int                        held_count;
    logic                      held_overflow;
    logic [TOP_W-1:0]          model_top_count;

    // Expected ranked results, oldest first
    result_t ranked_expect[$];

    // Bookkeeping
    int cycle_count;
    int mismatch_count;
    int requests_sent;
    int sets_closed;
    int results_seen;
    int overflow_runs;
    int sender_idle_pct;

    // Distance of a cell from the nearest board edge; off-board cells count as 0
    function automatic int edge_depth(logic [POS_W-1:0] pos);
        int row;
        int col;
        int depth;
        if (pos >= BOARD_CELLS)
            return 0;
        row   = pos / BOARD_SIDE;
        col   = pos % BOARD_SIDE;
        depth = row;
        if (col < depth)
            depth = col;
        if (BOARD_SIDE - 1 - row < depth)
            depth = BOARD_SIDE - 1 - row;
        if (BOARD_SIDE - 1 - col < depth)
            depth = BOARD_SIDE - 1 - col;
        return depth;
    endfunction

    // True when pair a sits strictly below pair b: lower score, or equal
    // score and a shallower cell. Fully equal pairs never reorder.
    function automatic logic ranks_lower(logic signed [SCORE_W-1:0] a_score,
                                         logic [POS_W-1:0] a_pos,
                                         logic signed [SCORE_W-1:0] b_score,
                                         logic [POS_W-1:0] b_pos);
        if (a_score != b_score)
            return a_score < b_score;
        return edge_depth(a_pos) < edge_depth(b_pos);
    endfunction

    // Insert one accepted request; on a final request queue the ranked list
    // and close the set.
    task automatic rank_insert(in_req_t r);
        int      slot;
        int      limit;
        int      emit;
        result_t want;
        if (held_count < CAPACITY)
        begin
            slot = held_count;
            while (slot > 0 && ranks_lower(held_score[slot-1], held_pos[slot-1],
                                           r.score, r.position))
            begin
                held_pos[slot]   = held_pos[slot-1];
                held_score[slot] = held_score[slot-1];
                slot--;
            end
            held_pos[slot]   = r.position;
            held_score[slot] = r.score;
            held_count++;
        end
        else
        begin
            // Store full: dropped without comparison, final marker still counts
            held_overflow = 1'b1;
        end

        if (r.final_item)
        begin
            limit = model_top_count;
            if (limit == 0)
                limit = 1;
            if (limit > MAX_OUT)
                limit = MAX_OUT;
            emit = (held_count < limit) ? held_count : limit;
            for (int i = 0; i < emit; i++)
            begin
                want.out_position = held_pos[i];
                want.out_score    = held_score[i];
                want.rank_index   = i[RANK_W-1:0];
                want.end_of_list  = (i == emit - 1);
                want.overflowed   = (i == emit - 1) && held_overflow;
                ranked_expect.push_back(want);
            end
            if (held_overflow)
                overflow_runs++;
            sets_closed++;
            held_count    = 0;
            held_overflow = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        mismatch_count++;
        $display("MISMATCH cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got, want);
    endtask

    // Results cannot be held off, so every strobed cycle is a result.
    // Sampling right at the edge sees the values of the cycle that ends.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (ranked_expect.size() == 0)
            begin
                report_mismatch("result with nothing expected", result, '0);
            end
            else
            begin
                want = ranked_expect.pop_front();
                if (result.out_position !== want.out_position)
                    report_mismatch("out_position", result.out_position, want.out_position);
                if (result.out_score !== want.out_score)
                    report_mismatch("out_score", result.out_score, want.out_score);
                if (result.rank_index !== want.rank_index)
                    report_mismatch("rank_index", result.rank_index, want.rank_index);
                if (result.end_of_list !== want.end_of_list)
                    report_mismatch("end_of_list", result.end_of_list, want.end_of_list);
                if (result.overflowed !== want.overflowed)
                    report_mismatch("overflowed", result.overflowed, want.overflowed);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d results outstanding",
                     cycle_count, ranked_expect.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers. All entered just after a rising edge; inputs change by NBA.
    // ------------------------------------------------------------------

    // Offer one request and wait until it is taken (start high, busy low at
    // an edge). start stays high on return so back-to-back requests need no
    // second assignment in the same step.
    task automatic send_request(logic [POS_W-1:0] pos, logic [SCORE_W-1:0] score,
                                logic fin);
        in_req_t r;
        in_req_t noise;
        r.position   = pos;
        r.score      = score;
        r.final_item = fin;
        // Idle cycles with junk on the bus; the block must ignore them
        while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            noise.position   = POS_W'($urandom);
            noise.score      = SCORE_W'($urandom);
            noise.final_item = 1'($urandom);
            start <= 1'b0;
            req   <= noise;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests_sent++;
        rank_insert(r);
    endtask

    // Wait out all pending results, then write top_count while the block is idle
    task automatic write_top_count(logic [TOP_W-1:0] value);
        start <= 1'b0;
        while (ranked_expect.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we          <= 1'b0;
        model_top_count  = value;
    endtask

    function automatic logic [POS_W-1:0] rand_position();
        if ($urandom_range(0, 9) == 0)
            return POS_W'($urandom_range(BOARD_CELLS, 255));
        return POS_W'($urandom_range(0, BOARD_CELLS - 1));
    endfunction

    // Mix of full-range, clustered (to force ties) and extreme scores
    function automatic logic [SCORE_W-1:0] rand_score();
        unique case ($urandom_range(0, 3))
            0:       return SCORE_W'($urandom_range(0, 8) - 4);
            1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return SCORE_W'($urandom);
        endcase
    endfunction

    function automatic logic [TOP_W-1:0] rand_top_count();
        unique case ($urandom_range(0, 5))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd64;
            3:       return 7'd127;
            default: return TOP_W'($urandom_range(0, 127));
        endcase
    endfunction

    // One set of random pairs, the last one final
    task automatic send_random_set(int size);
        for (int i = 0; i < size; i++)
            send_request(rand_position(), rand_score(), i == size - 1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_single_pair();
        send_request(8'd112, 32'd0, 1'b1);
    endtask

    // Field extremes: lowest/highest score, first/last cell, top off-board code
    task automatic test_field_extremes();
        send_request(8'd0,   32'h8000_0000, 1'b0);
        send_request(8'd224, 32'h7fff_ffff, 1'b0);
        send_request(8'd255, 32'hffff_ffff, 1'b0);
        send_request(8'd112, 32'd1,         1'b1);
    endtask

    // Equal scores: deeper cell wins; equal depth keeps arrival order.
    // Off-board cell ranks with depth 0.
    task automatic test_tie_breaks();
        send_request(8'd0,   32'd5, 1'b0);  // corner, depth 0
        send_request(8'd112, 32'd5, 1'b0);  // center, depth 7
        send_request(8'd16,  32'd5, 1'b0);  // depth 1
        send_request(8'd14,  32'd5, 1'b0);  // corner, equal to first pair
        send_request(8'd230, 32'd5, 1'b0);  // off the board
        send_request(8'd224, 32'd5, 1'b0);  // corner
        send_request(8'd17,  32'd5, 1'b1);  // depth 1, behind cell 16
    endtask

    // top_count zero acts as one; small limits truncate; larger than the set
    task automatic test_top_count_limits();
        write_top_count(7'd0);
        send_random_set(3);
        write_top_count(7'd1);
        send_random_set(2);
        write_top_count(7'd10);
        send_random_set(3);
    endtask

    // Sets longer than the output cap, with top_count at 64 and above it
    task automatic test_long_sets();
        write_top_count(7'd64);
        send_random_set(66);
        write_top_count(7'd127);
        send_random_set(66);
    endtask

    // Overrun the store, with drops while full and a dropped final pair
    task automatic test_overflow();
        write_top_count(7'd64);
        for (int i = 0; i < CAPACITY + 1; i++)
            send_request(rand_position(), rand_score(), 1'b0);
        send_request(8'd112, 32'h7fff_ffff, 1'b1);  // dropped, still closes the set
        send_random_set(2);                          // overflow must not linger
    endtask

    task automatic test_random_traffic(int idle_pct, int n_items);
        int sent;
        int size;
        int pick;
        sender_idle_pct = idle_pct;
        sent            = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                size = $urandom_range(1, 12);
            else if (pick < 95)
                size = $urandom_range(13, 40);
            else
                size = $urandom_range(60, 80);
            send_random_set(size);
            sent += size;
            if ($urandom_range(0, 99) < 15)
                write_top_count(rand_top_count());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        req             = '0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        cycle_count     = 0;
        mismatch_count  = 0;
        requests_sent   = 0;
        sets_closed     = 0;
        results_seen    = 0;
        overflow_runs   = 0;
        sender_idle_pct = 0;
        held_count      = 0;
        held_overflow   = 1'b0;
        model_top_count = 7'd64;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs at the reset value of top_count first
        test_single_pair();
        test_field_extremes();
        test_tie_breaks();
        test_top_count_limits();
        test_long_sets();
        test_overflow();

        // Random part: no idling, heavy sender idling, moderate idling
        write_top_count(rand_top_count());
        test_random_traffic(0, 30);
        test_random_traffic(64, 30);
        test_random_traffic(35, 30);

        // Drain, then allow the block's latency for any stray result
        start <= 1'b0;
        while (ranked_expect.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        while (ranked_expect.size() != 0)
        begin
            report_mismatch("expected result never arrived", '0, ranked_expect.pop_front());
        end

        $display("Covered %0d requests in %0d sets, %0d ranked results checked, %0d overflow runs.",
                 requests_sent, sets_closed, results_seen, overflow_runs);
        $display("top_count swept over 0, 1, 64, 127 and random values; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### descending_pair_sorter.f
design/dps_pkg.sv
design/dps_cell.sv
design/descending_pair_sorter.sv
design/dps_checker.sv
tb/tb_descending_pair_sorter.sv
